// ===== rtl/tfcn_pkg.sv =====
package tfcn_pkg;

  // Coordinate and intermediate widths.
  localparam int CW   = 32;            // input coordinate
  localparam int DW   = CW + 1;        // edge vector component
  localparam int PW   = 2 * DW;        // one cross product term
  localparam int NW   = PW + 1;        // cross product component
  localparam int KW   = $clog2(NW + 1);
  localparam int RW   = 31;            // reduced component magnitude
  localparam int SW   = 64;            // sum of squares
  localparam int LW   = SW / 2;        // square root
  localparam int FB   = 14;            // normal fraction bits
  localparam int OW   = 16;            // normal output width
  localparam int QW   = FB + 1;        // quotient magnitude
  localparam int NUMW = RW + QW + 1;   // dividend
  localparam int DRW  = LW + 2;        // divider remainder

  typedef struct packed {
    logic                   valid;
    logic                   changed;
    logic [2:0]             neg;
    logic [2:0][RW-1:0]     a;
    logic [2:0][CW-1:0]     z;
  } tag_t;

  // Number of significant bits of v.
  function automatic logic [KW-1:0] bitlen(input logic [NW-1:0] v);
    logic [KW-1:0] n;
    n = '0;
    for (int i = 0; i < NW; i++) begin
      if (v[i]) n = KW'(i + 1);
    end
    return n;
  endfunction

endpackage

// ===== rtl/tfcn_sqrt.sv =====
module tfcn_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [tfcn_pkg::SW-1:0] s_in,
  input  tfcn_pkg::tag_t          tag_in,
  output logic [tfcn_pkg::LW-1:0] root_out,
  output tfcn_pkg::tag_t          tag_out
);

  localparam int LW = tfcn_pkg::LW;
  localparam int SW = tfcn_pkg::SW;
  localparam int RMW = LW + 3;

  logic [SW-1:0]  s_a    [LW+1];
  logic [RMW-1:0] rem_a  [LW+1];
  logic [LW-1:0]  root_a [LW+1];
  tfcn_pkg::tag_t tag_a  [LW+1];

  assign s_a[0]    = s_in;
  assign rem_a[0]  = '0;
  assign root_a[0] = '0;
  assign tag_a[0]  = tag_in;

  // One result bit per stage, two radicand bits consumed per stage.
  for (genvar j = 0; j < LW; j++) begin : g_step
    logic [RMW+1:0] t;
    logic [RMW+1:0] trial;
    logic           ge;

    always_comb begin
      t     = {rem_a[j], s_a[j][SW-1 -: 2]};
      trial = (RMW+2)'({root_a[j], 2'b01});
      ge    = (t >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_a[j+1].valid <= 1'b0;
      end else begin
        tag_a[j+1] <= tag_a[j];
      end
      s_a[j+1]    <= s_a[j] << 2;
      rem_a[j+1]  <= ge ? RMW'(t - trial) : RMW'(t);
      root_a[j+1] <= {root_a[j][LW-2:0], ge};
    end
  end

  assign root_out = root_a[LW];
  assign tag_out  = tag_a[LW];

endmodule

// ===== rtl/tfcn_div.sv =====
module tfcn_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tfcn_pkg::LW-1:0]      len_in,
  input  tfcn_pkg::tag_t               tag_in,
  output logic [2:0][tfcn_pkg::QW-1:0] q_out,
  output logic [tfcn_pkg::LW-1:0]      len_out,
  output tfcn_pkg::tag_t               tag_out
);

  localparam int LW   = tfcn_pkg::LW;
  localparam int QW   = tfcn_pkg::QW;
  localparam int DRW  = tfcn_pkg::DRW;
  localparam int NUMW = tfcn_pkg::NUMW;

  logic [LW-1:0]  len_a [QW+1];
  tfcn_pkg::tag_t tag_a [QW+1];

  assign len_a[0] = len_in;
  assign tag_a[0] = tag_in;

  for (genvar j = 0; j < QW; j++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        tag_a[j+1].valid <= 1'b0;
      end else begin
        tag_a[j+1] <= tag_a[j];
      end
      len_a[j+1] <= len_a[j];
    end
  end

  // Restoring division of (a * 2^(F+1) + len) by 2*len, one quotient bit a stage.
  // The upper dividend bits always stay below the divisor, so they seed the remainder.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [NUMW-1:0] num;
    logic [DRW-1:0]  rem_a [QW+1];
    logic [QW-1:0]   low_a [QW+1];
    logic [QW-1:0]   q_a   [QW+1];

    assign num      = (NUMW'(tag_in.a[l]) << QW) + NUMW'(len_in);
    assign rem_a[0] = DRW'(num[NUMW-1:QW]);
    assign low_a[0] = num[QW-1:0];
    assign q_a[0]   = '0;

    for (genvar j = 0; j < QW; j++) begin : g_step
      logic [DRW-1:0] t;
      logic [DRW-1:0] d;
      logic           ge;

      always_comb begin
        t  = {rem_a[j][DRW-2:0], low_a[j][QW-1]};
        d  = DRW'({len_a[j], 1'b0});
        ge = (t >= d);
      end

      always_ff @(posedge clk) begin
        rem_a[j+1] <= ge ? (t - d) : t;
        low_a[j+1] <= low_a[j] << 1;
        q_a[j+1]   <= {q_a[j][QW-2:0], ge};
      end
    end

    assign q_out[l] = q_a[QW];
  end

  assign len_out = len_a[QW];
  assign tag_out = tag_a[QW];

endmodule

// ===== rtl/triangle_floor_clamp_normal_unit.sv =====
// Floor clamp of one triangle with face normal recompute.
//
// Channels: a triangle is transferred when start is high and busy is low; busy
// is always low, so one triangle may be sent on every clock. Each triangle
// yields one result on the output ports, marked by done for exactly one
// cycle: the clamped z values, the changed flag and, when changed is set, the
// unit normal in signed Q1.14 (zero when nothing was clamped or the clamped
// triangle is degenerate).
// The floor register is written through cfg_valid/cfg_ready/cfg_data; ready
// is always high. Write it only while no triangle is in flight.
// From the transfer to done the pipeline has nine stages of clamp,
// edge vectors, cross product, magnitude reduction and squares, 32 stages of
// the pipelined square root (one root bit each) and 15 stages of the three
// dividers (one quotient bit each), plus the output register.
// Throughput is one triangle per clock. The receiver cannot stall, so nothing
// ever holds back the pipeline.
// Synchronous reset clears every valid bit and sets the floor to zero.
module triangle_floor_clamp_normal_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [tfcn_pkg::CW-1:0] v0_x,
  input  logic signed [tfcn_pkg::CW-1:0] v0_y,
  input  logic signed [tfcn_pkg::CW-1:0] v0_z,
  input  logic signed [tfcn_pkg::CW-1:0] v1_x,
  input  logic signed [tfcn_pkg::CW-1:0] v1_y,
  input  logic signed [tfcn_pkg::CW-1:0] v1_z,
  input  logic signed [tfcn_pkg::CW-1:0] v2_x,
  input  logic signed [tfcn_pkg::CW-1:0] v2_y,
  input  logic signed [tfcn_pkg::CW-1:0] v2_z,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tfcn_pkg::CW-1:0]        cfg_data,
  output logic                           done,
  output logic signed [tfcn_pkg::CW-1:0] v0_z_out,
  output logic signed [tfcn_pkg::CW-1:0] v1_z_out,
  output logic signed [tfcn_pkg::CW-1:0] v2_z_out,
  output logic signed [tfcn_pkg::OW-1:0] normal_x,
  output logic signed [tfcn_pkg::OW-1:0] normal_y,
  output logic signed [tfcn_pkg::OW-1:0] normal_z,
  output logic                           changed
);

  localparam int CW = tfcn_pkg::CW;
  localparam int DW = tfcn_pkg::DW;
  localparam int PW = tfcn_pkg::PW;
  localparam int NW = tfcn_pkg::NW;
  localparam int KW = tfcn_pkg::KW;
  localparam int RW = tfcn_pkg::RW;
  localparam int SW = tfcn_pkg::SW;
  localparam int LW = tfcn_pkg::LW;
  localparam int QW = tfcn_pkg::QW;
  localparam int OW = tfcn_pkg::OW;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic signed [CW-1:0] floor_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      floor_z <= cfg_data;
    end
  end

  // Stage 1: clamp.
  logic                       s1_valid;
  logic                       s1_changed;
  logic signed [2:0][CW-1:0]  s1_x;
  logic signed [2:0][CW-1:0]  s1_y;
  logic [2:0][CW-1:0]         s1_z;
  logic [2:0]                 lo;

  assign lo = {v2_z < floor_z, v1_z < floor_z, v0_z < floor_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_changed <= |lo;
    s1_x       <= {v2_x, v1_x, v0_x};
    s1_y       <= {v2_y, v1_y, v0_y};
    s1_z[0]    <= lo[0] ? floor_z : v0_z;
    s1_z[1]    <= lo[1] ? floor_z : v1_z;
    s1_z[2]    <= lo[2] ? floor_z : v2_z;
  end

  // Stage 2: edge vectors u = v1 - v0, w = v2 - v0.
  logic                  s2_valid;
  logic                  s2_changed;
  logic [2:0][CW-1:0]    s2_z;
  logic signed [DW-1:0]  ux, uy, uz, wx, wy, wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_changed <= s1_changed;
    s2_z       <= s1_z;
    ux <= DW'($signed(s1_x[1])) - DW'($signed(s1_x[0]));
    uy <= DW'($signed(s1_y[1])) - DW'($signed(s1_y[0]));
    uz <= DW'($signed(s1_z[1])) - DW'($signed(s1_z[0]));
    wx <= DW'($signed(s1_x[2])) - DW'($signed(s1_x[0]));
    wy <= DW'($signed(s1_y[2])) - DW'($signed(s1_y[0]));
    wz <= DW'($signed(s1_z[2])) - DW'($signed(s1_z[0]));
  end

  // Stage 3: six cross product terms.
  logic                  s3_valid;
  logic                  s3_changed;
  logic [2:0][CW-1:0]    s3_z;
  logic signed [PW-1:0]  p0, p1, p2, p3, p4, p5;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_changed <= s2_changed;
    s3_z       <= s2_z;
    p0 <= PW'(uy) * PW'(wz);
    p1 <= PW'(uz) * PW'(wy);
    p2 <= PW'(uz) * PW'(wx);
    p3 <= PW'(ux) * PW'(wz);
    p4 <= PW'(ux) * PW'(wy);
    p5 <= PW'(uy) * PW'(wx);
  end

  // Stage 4: normal components.
  logic                        s4_valid;
  logic                        s4_changed;
  logic [2:0][CW-1:0]          s4_z;
  logic signed [2:0][NW-1:0]   s4_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_changed <= s3_changed;
    s4_z       <= s3_z;
    s4_n[0]    <= NW'(p0) - NW'(p1);
    s4_n[1]    <= NW'(p2) - NW'(p3);
    s4_n[2]    <= NW'(p4) - NW'(p5);
  end

  // Stage 5: sign and magnitude.
  logic                 s5_valid;
  logic                 s5_changed;
  logic [2:0][CW-1:0]   s5_z;
  logic [2:0]           s5_neg;
  logic [2:0][NW-1:0]   s5_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_changed <= s4_changed;
    s5_z       <= s4_z;
    for (int i = 0; i < 3; i++) begin
      s5_neg[i] <= s4_n[i][NW-1];
      s5_mag[i] <= s4_n[i][NW-1] ? (~s4_n[i] + NW'(1)) : s4_n[i];
    end
  end

  // Stage 6: shift amount that brings the largest magnitude into RW bits.
  logic                 s6_valid;
  logic                 s6_changed;
  logic [2:0][CW-1:0]   s6_z;
  logic [2:0]           s6_neg;
  logic [2:0][NW-1:0]   s6_mag;
  logic [KW-1:0]        s6_k;
  logic [KW-1:0]        maxlen;

  assign maxlen = tfcn_pkg::bitlen(s5_mag[0] | s5_mag[1] | s5_mag[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
    s6_changed <= s5_changed;
    s6_z       <= s5_z;
    s6_neg     <= s5_neg;
    s6_mag     <= s5_mag;
    s6_k       <= (maxlen > KW'(RW)) ? (maxlen - KW'(RW)) : '0;
  end

  // Stage 7: reduced magnitudes.
  logic                 s7_valid;
  logic                 s7_changed;
  logic [2:0][CW-1:0]   s7_z;
  logic [2:0]           s7_neg;
  logic [2:0][RW-1:0]   s7_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= s6_valid;
    end
    s7_changed <= s6_changed;
    s7_z       <= s6_z;
    s7_neg     <= s6_neg;
    for (int i = 0; i < 3; i++) begin
      s7_a[i] <= RW'(s6_mag[i] >> s6_k);
    end
  end

  // Stage 8: squares.
  tfcn_pkg::tag_t          s8_tag;
  logic [2:0][2*RW-1:0]    s8_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_tag.valid <= 1'b0;
    end else begin
      s8_tag.valid <= s7_valid;
    end
    s8_tag.changed <= s7_changed;
    s8_tag.neg     <= s7_neg;
    s8_tag.a       <= s7_a;
    s8_tag.z       <= s7_z;
    for (int i = 0; i < 3; i++) begin
      s8_sq[i] <= (2*RW)'(s7_a[i]) * (2*RW)'(s7_a[i]);
    end
  end

  // Stage 9: sum of squares.
  tfcn_pkg::tag_t  s9_tag;
  logic [SW-1:0]   s9_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_tag.valid <= 1'b0;
    end else begin
      s9_tag <= s8_tag;
    end
    s9_s <= SW'(s8_sq[0]) + SW'(s8_sq[1]) + SW'(s8_sq[2]);
  end

  tfcn_pkg::tag_t  sq_tag;
  logic [LW-1:0]   sq_len;

  tfcn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .s_in     (s9_s),
    .tag_in   (s9_tag),
    .root_out (sq_len),
    .tag_out  (sq_tag)
  );

  tfcn_pkg::tag_t       dv_tag;
  logic [LW-1:0]        dv_len;
  logic [2:0][QW-1:0]   dv_q;

  tfcn_div u_div (
    .clk     (clk),
    .rst     (rst),
    .len_in  (sq_len),
    .tag_in  (sq_tag),
    .q_out   (dv_q),
    .len_out (dv_len),
    .tag_out (dv_tag)
  );

  // Output register: sign, and zero when unchanged or degenerate.
  logic                 keep;
  logic [2:0][OW-1:0]   nrm;

  assign keep = dv_tag.changed && (dv_len != '0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!keep) begin
        nrm[i] = '0;
      end else if (dv_tag.neg[i]) begin
        nrm[i] = '0 - OW'(dv_q[i]);
      end else begin
        nrm[i] = OW'(dv_q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_tag.valid;
    end
    changed  <= dv_tag.changed;
    v0_z_out <= dv_tag.z[0];
    v1_z_out <= dv_tag.z[1];
    v2_z_out <= dv_tag.z[2];
    normal_x <= nrm[0];
    normal_y <= nrm[1];
    normal_z <= nrm[2];
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  localparam int CW = tfcn_pkg::CW;
  localparam int OW = tfcn_pkg::OW;
  localparam int RW = tfcn_pkg::RW;
  localparam int FB = tfcn_pkg::FB;

  typedef struct {
    logic signed [CW-1:0] c[9];
  } tri_t;

  typedef struct {
    logic signed [CW-1:0] z[3];
    logic signed [OW-1:0] n[3];
    logic                 chg;
  } face_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] vin[9];
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CW-1:0] cfg_data = '0;
  logic done;
  logic signed [CW-1:0] z0_out, z1_out, z2_out;
  logic signed [OW-1:0] nx_out, ny_out, nz_out;
  logic chg_out;

  tri_t  pending_tris[$];
  face_t expected_faces[$];
  logic signed [CW-1:0] floor_q = '0;
  int gap_left = 0;
  bit burst = 1'b0;
  int errors = 0;

  initial foreach (vin[i]) vin[i] = '0;

  always #6 clk = ~clk;

  triangle_floor_clamp_normal_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .v0_x(vin[0]), .v0_y(vin[1]), .v0_z(vin[2]),
    .v1_x(vin[3]), .v1_y(vin[4]), .v1_z(vin[5]),
    .v2_x(vin[6]), .v2_y(vin[7]), .v2_z(vin[8]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .v0_z_out(z0_out), .v1_z_out(z1_out), .v2_z_out(z2_out),
    .normal_x(nx_out), .normal_y(ny_out), .normal_z(nz_out), .changed(chg_out)
  );

  function automatic logic [63:0] isqrt(logic [63:0] s);
    logic [63:0] r, b;
    r = '0;
    b = 64'h1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic face_t clamp_and_normal(tri_t t, logic signed [CW-1:0] fl);
    face_t r;
    logic signed [CW-1:0] v[9];
    logic signed [127:0] ux, uy, uz, wx, wy, wz;
    logic signed [127:0] cr[3];
    logic [127:0] mag[3];
    logic [63:0] a[3];
    logic [63:0] s, len, q;
    int ml, k;
    v = t.c;
    r.chg = 1'b0;
    for (int i = 2; i < 9; i += 3) begin
      if (v[i] < fl) begin
        v[i] = fl;
        r.chg = 1'b1;
      end
    end
    r.z[0] = v[2];
    r.z[1] = v[5];
    r.z[2] = v[8];
    foreach (r.n[i]) r.n[i] = '0;
    if (r.chg) begin
      ux = v[3] - v[0]; uy = v[4] - v[1]; uz = v[5] - v[2];
      wx = v[6] - v[0]; wy = v[7] - v[1]; wz = v[8] - v[2];
      cr[0] = uy * wz - uz * wy;
      cr[1] = uz * wx - ux * wz;
      cr[2] = ux * wy - uy * wx;
      ml = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = cr[i][127] ? -cr[i] : cr[i];
        for (int b = 0; b < 128; b++) if (mag[i][b] && b + 1 > ml) ml = b + 1;
      end
      k = (ml > RW) ? ml - RW : 0;
      s = '0;
      for (int i = 0; i < 3; i++) begin
        a[i] = 64'(mag[i] >> k);
        s = s + a[i] * a[i];
      end
      len = isqrt(s);
      if (len != 0) begin
        for (int i = 0; i < 3; i++) begin
          q = ((a[i] << (FB + 1)) + len) / (2 * len);
          r.n[i] = cr[i][127] ? OW'(-q) : OW'(q);
        end
      end
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_z(logic signed [CW-1:0] fl);
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return fl;
      2: return fl + $urandom_range(0, 4095);
      3: return fl - $urandom_range(1, 4095);
      default: return fl + $signed($urandom_range(0, 2097151)) - 1048576;
    endcase
  endfunction

  function automatic tri_t rand_tri(logic signed [CW-1:0] fl);
    tri_t t;
    bit wide;
    wide = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < 9; i++) begin
      if (i % 3 == 2) t.c[i] = rand_z(fl);
      else if (wide) t.c[i] = $urandom;
      else t.c[i] = $signed($urandom_range(0, 2097151)) - 1048576;
    end
    return t;
  endfunction

  function automatic tri_t mk_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                  int x2, int y2, int z2);
    tri_t t;
    t.c[0] = x0; t.c[1] = y0; t.c[2] = z0;
    t.c[3] = x1; t.c[4] = y1; t.c[5] = z1;
    t.c[6] = x2; t.c[7] = y2; t.c[8] = z2;
    return t;
  endfunction

  // Driver: one transfer per accepted start, with a drawn gap before the next.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_faces.push_back(clamp_and_normal(pending_tris.pop_front(), floor_q));
        if ($urandom_range(0, 49) == 0) burst = ~burst;
        gap_left = burst ? 0 : $urandom_range(0, 17);
        if (gap_left == 0 && pending_tris.size() > 0) begin
          foreach (vin[i]) vin[i] <= pending_tris[0].c[i];
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end else if (pending_tris.size() > 0) begin
          foreach (vin[i]) vin[i] <= pending_tris[0].c[i];
          start <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) floor_q <= cfg_data;
  end

  // Monitor: every done strobe is one result transfer.
  always @(posedge clk) begin
    face_t e;
    if (!rst && done) begin
      if (expected_faces.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result z=%0d %0d %0d", z0_out, z1_out, z2_out);
      end else begin
        e = expected_faces.pop_front();
        if (z0_out !== e.z[0] || z1_out !== e.z[1] || z2_out !== e.z[2] ||
            nx_out !== e.n[0] || ny_out !== e.n[1] || nz_out !== e.n[2] ||
            chg_out !== e.chg) begin
          errors++;
          if (errors <= 10)
            $display("exp z %0d %0d %0d n %0d %0d %0d c %0b, got z %0d %0d %0d n %0d %0d %0d c %0b",
                     e.z[0], e.z[1], e.z[2], e.n[0], e.n[1], e.n[2], e.chg,
                     z0_out, z1_out, z2_out, nx_out, ny_out, nz_out, chg_out);
        end
      end
    end
  end

  task automatic write_floor(logic [CW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    @(posedge clk);
    while (pending_tris.size() > 0 || start || expected_faces.size() > 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  initial begin
    logic [CW-1:0] floors[8];
    int min_i, max_i, one;
    min_i = 32'h8000_0000;
    max_i = 32'h7fff_ffff;
    one = 32'h0001_0000;
    floors = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000,
               32'h0003_8000, $urandom, $urandom, 32'h0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_floor(32'h0);
    pending_tris.push_back(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tris.push_back(mk_tri(0, 0, -one, one, 0, -one, 0, one, -one));
    pending_tris.push_back(mk_tri(0, 0, one, one, 0, -one, 0, one, 2 * one));
    pending_tris.push_back(mk_tri(min_i, min_i, min_i, min_i, min_i, min_i,
                                  min_i, min_i, min_i));
    pending_tris.push_back(mk_tri(max_i, max_i, max_i, max_i, max_i, max_i,
                                  max_i, max_i, max_i));
    pending_tris.push_back(mk_tri(min_i, min_i, min_i, max_i, min_i, 0,
                                  min_i, max_i, max_i));
    pending_tris.push_back(mk_tri(max_i, min_i, -1, min_i, max_i, min_i,
                                  max_i, max_i, 0));
    // Collinear vertices stay degenerate after the clamp.
    pending_tris.push_back(mk_tri(0, 0, -5, one, one, -3, 2 * one, 2 * one, -7));
    pending_tris.push_back(mk_tri(one, 0, 0, 0, one, 0, 0, 0, 0));
    pending_tris.push_back(mk_tri(3, -7, -1, -9, 4, 6, 11, 2, 5));
    pending_tris.push_back(mk_tri(min_i, max_i, 7, max_i, min_i, -7, 0, 0, min_i));
    drain();

    foreach (floors[p]) begin
      write_floor(floors[p]);
      @(posedge clk);
      pending_tris.push_back(mk_tri(0, 0, floors[p], one, 0, floors[p],
                                    0, one, floors[p] - 1));
      for (int i = 0; i < 225; i++) pending_tris.push_back(rand_tri(floors[p]));
      drain();
    end

    if (errors == 0) begin
      $display("triangle_floor_clamp_normal_unit: match");
    end else begin
      $display("triangle_floor_clamp_normal_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("triangle_floor_clamp_normal_unit: mismatch");
    $finish;
  end

endmodule
